// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL; only fraction_add_reduce includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== sv/far_pkg.sv =====
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and codes of the fraction adder.
// ----------------------------------------------------------------------------
package far_pkg;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_G1_START, S_G1_WAIT, S_Q_START, S_Q_WAIT,
        S_L_START, S_L_WAIT, S_K1_START, S_K1_WAIT, S_P1_START, S_P1_WAIT,
        S_LCM_START, S_LCM_WAIT,
        S_K2_START, S_K2_WAIT, S_P2_START, S_P2_WAIT, S_SUM,
        S_G2_START, S_G2_WAIT, S_RN_START, S_RN_WAIT, S_RD_START, S_RD_WAIT,
        S_FINISH, S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;
endpackage

// ===== sv/far_alu.sv =====
// ----------------------------------------------------------------------------
// far_alu
// Bit-serial unsigned multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module far_alu import far_pkg::*; #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_alu_ctl     i_ctl,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    t_op          r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0] r_a, n_a;   // multiplicand or dividend shift register
    logic [W-1:0] r_b, n_b;   // multiplier or divisor
    logic [W-1:0] r_acc, n_acc; // product or partial remainder
    logic [W:0]   w_trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        w_trial = {r_acc, r_a[W-1]} - {1'b0, r_b};
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_op   = i_ctl.op;
            n_cnt  = CW'(W);
            n_a    = i_a;
            n_b    = i_b;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_op == OP_MUL) begin
                // Product low bits only; callers pre-check for overflow.
                if (r_b[0]) n_acc = r_acc + r_a;
                n_a = {r_a[W-2:0], 1'b0};
                n_b = {1'b0, r_b[W-1:1]};
            end else begin
                if (!w_trial[W]) begin
                    n_acc = w_trial[W-1:0];
                    n_a   = {r_a[W-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[W-2:0], r_a[W-1]};
                    n_a   = {r_a[W-2:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end

    assign o_done = r_done;
    assign o_quo  = (r_op == OP_MUL) ? r_acc : r_a;
    assign o_rem  = r_acc;
endmodule

// ===== sv/fraction_add_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_add_reduce
// Adds two fractions and reduces the sum by its greatest common divisor.
// ----------------------------------------------------------------------------
// Input channel (s_axis): one transaction carries both fractions. Output
// channel (m_axis): one transaction per input with the reduced sum and a
// status code (0 ok, 1 zero denominator, 2 overflow; sums are zero on error).
// All arithmetic runs on one shared 66-bit bit-serial unit that multiplies
// or divides: each operation starts, shifts every bit, then flags done.
// The work per item grows with the Euclid steps of both gcds, and error
// items leave early.
// One item is worked at a time; s_axis_tready is high only while idle.
// The result is held in the output register until the receiver takes it,
// so a stall on m_axis simply holds the block. Reset drops any item in
// flight and clears the output valid.
`include "assert_macros.svh"
module fraction_add_reduce import far_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_numerator[31:0], first_denominator[62:32],
    // second_numerator[94:63], second_denominator[125:95]
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sum_numerator[31:0], sum_denominator[62:32], status[64:63]
    output logic [71:0]  m_axis_tdata
);
    localparam int W = 66; // fits any 64-bit signed magnitude plus headroom
    localparam logic [W-1:0] MAXV = W'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);

    t_state       r_st, n_st;
    logic         r_s1, r_s2, r_ss, n_s1, n_s2, n_ss;
    logic [W-1:0] r_m1, r_m2, r_d1, r_d2, n_m1, n_m2, n_d1, n_d2;
    logic [W-1:0] r_x, r_y, n_x, n_y;          // Euclid pair
    logic [W-1:0] r_lcm, r_t, r_sm, n_lcm, n_t, n_sm;
    logic [1:0]   r_status, n_status;
    logic [31:0]  r_on, n_on;
    logic [30:0]  r_od, n_od;
    logic         r_ov, n_ov;

    t_alu_ctl     w_ctl;
    logic [W-1:0] w_a, w_b, w_quo, w_rem;
    logic         w_done;
    logic [W-1:0] w_lim1, w_lim2, w_lims;

    far_alu #(.W(W)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_a(w_a), .i_b(w_b),
        .o_done(w_done), .o_quo(w_quo), .o_rem(w_rem)
    );

    assign w_lim1 = r_s1 ? MAXV + 1'b1 : MAXV;
    assign w_lim2 = r_s2 ? MAXV + 1'b1 : MAXV;
    assign w_lims = r_ss ? MAXV + 1'b1 : MAXV;

    always_comb begin
        n_st = r_st; n_s1 = r_s1; n_s2 = r_s2; n_ss = r_ss;
        n_m1 = r_m1; n_m2 = r_m2; n_d1 = r_d1; n_d2 = r_d2;
        n_x = r_x; n_y = r_y; n_lcm = r_lcm; n_t = r_t; n_sm = r_sm;
        n_status = r_status; n_on = r_on; n_od = r_od; n_ov = r_ov;
        w_ctl = '{start: 1'b0, op: OP_DIV};
        w_a = r_x; w_b = r_y;
        case (r_st)
            S_IDLE: if (s_axis_tvalid) begin
                n_s1 = s_axis_tdata[31];
                n_s2 = s_axis_tdata[94];
                n_m1 = W'(s_axis_tdata[31] ? 32'(-s_axis_tdata[31:0])
                                           : s_axis_tdata[31:0]);
                n_m2 = W'(s_axis_tdata[94] ? 32'(-s_axis_tdata[94:63])
                                           : s_axis_tdata[94:63]);
                n_d1 = W'(s_axis_tdata[62:32]);
                n_d2 = W'(s_axis_tdata[125:95]);
                n_st = S_CHECK;
            end
            S_CHECK: begin
                n_on = '0; n_od = '0;
                if (r_d1 == '0 || r_d2 == '0) begin
                    n_status = ST_ZERO_DEN; n_st = S_OUT;
                end else if (r_m1 > w_lim1 || r_m2 > w_lim2 || r_d1 > MAXV || r_d2 > MAXV) begin
                    n_status = ST_OVERFLOW; n_st = S_OUT;
                end else begin
                    n_x = r_d1; n_y = r_d2; n_st = S_G1_START;
                end
            end
            S_G1_START, S_G2_START: begin
                if (r_y == '0) begin
                    n_st = (r_st == S_G1_START) ? S_Q_START : S_RN_START;
                end else begin
                    w_ctl = '{start: 1'b1, op: OP_DIV};
                    n_st = (r_st == S_G1_START) ? S_G1_WAIT : S_G2_WAIT;
                end
            end
            S_G1_WAIT, S_G2_WAIT: if (w_done) begin
                n_x = r_y; n_y = w_rem;
                n_st = (r_st == S_G1_WAIT) ? S_G1_START : S_G2_START;
            end
            S_Q_START: begin
                w_a = r_d2; w_b = r_x; w_ctl = '{start: 1'b1, op: OP_DIV};
                n_st = S_Q_WAIT;
            end
            S_Q_WAIT: if (w_done) begin n_t = w_quo; n_st = S_L_START; end
            S_L_START: begin
                // d1*q overflows iff d1 > maxv/q
                w_a = MAXV; w_b = r_t; w_ctl = '{start: 1'b1, op: OP_DIV};
                n_st = S_L_WAIT;
            end
            S_L_WAIT: if (w_done) begin
                if (r_d1 > w_quo) begin n_status = ST_OVERFLOW; n_st = S_OUT; end
                else n_st = S_K1_START;
            end
            S_K1_START: begin
                // lcm/d1 = q; compute lim/q for the scale check
                w_a = w_lim1; w_b = r_t; w_ctl = '{start: 1'b1, op: OP_DIV};
                n_st = S_K1_WAIT;
            end
            S_K1_WAIT: if (w_done) begin
                if (r_m1 > w_quo) begin n_status = ST_OVERFLOW; n_st = S_OUT; end
                else n_st = S_P1_START;
            end
            S_P1_START: begin
                w_a = r_m1; w_b = r_t; w_ctl = '{start: 1'b1, op: OP_MUL};
                n_st = S_P1_WAIT;
            end
            S_P1_WAIT: if (w_done) begin
                n_m1 = w_quo; n_st = S_LCM_START;
            end
            S_LCM_START: begin
                w_a = r_d1; w_b = r_t; w_ctl = '{start: 1'b1, op: OP_MUL};
                n_st = S_LCM_WAIT;
            end
            S_LCM_WAIT: if (w_done) begin n_lcm = w_quo; n_st = S_K2_START; end
            S_K2_START: begin
                // k2 = lcm/d2 = d1/g; x holds g
                w_a = r_d1; w_b = r_x; w_ctl = '{start: 1'b1, op: OP_DIV};
                n_st = S_K2_WAIT;
            end
            S_K2_WAIT: if (w_done) begin n_t = w_quo; n_st = S_P2_START; end
            S_P2_START: begin
                // First pass checks lim/k2, second pass forms m2*k2.
                if (!r_ov) begin
                    w_a = w_lim2; w_b = r_t; w_ctl = '{start: 1'b1, op: OP_DIV};
                end else begin
                    w_a = r_m2; w_b = r_t; w_ctl = '{start: 1'b1, op: OP_MUL};
                end
                n_st = S_P2_WAIT;
            end
            S_P2_WAIT: if (w_done) begin
                if (!r_ov) begin
                    if (r_m2 > w_quo) begin n_status = ST_OVERFLOW; n_st = S_OUT; end
                    else begin n_ov = 1'b1; n_st = S_P2_START; end
                end else begin
                    n_m2 = w_quo; n_ov = 1'b0; n_st = S_SUM;
                end
            end
            S_SUM: begin
                if (r_s1 == r_s2) begin
                    n_ss = r_s1;
                    if (r_m1 > (r_s1 ? MAXV + 1'b1 : MAXV) ||
                        r_m2 > (r_s1 ? MAXV + 1'b1 : MAXV) - r_m1) begin
                        n_status = ST_OVERFLOW; n_st = S_OUT;
                    end else n_sm = r_m1 + r_m2;
                end else if (r_m1 >= r_m2) begin
                    n_sm = r_m1 - r_m2; n_ss = r_s1;
                end else begin
                    n_sm = r_m2 - r_m1; n_ss = r_s2;
                end
                if (n_st == S_SUM) begin
                    if (n_sm == '0) n_ss = 1'b0;
                    n_x = n_sm; n_y = r_lcm;
                    n_st = S_G2_START;
                end
            end
            S_RN_START: begin
                w_a = r_sm; w_b = r_x; w_ctl = '{start: 1'b1, op: OP_DIV};
                n_st = S_RN_WAIT;
            end
            S_RN_WAIT: if (w_done) begin n_sm = w_quo; n_st = S_RD_START; end
            S_RD_START: begin
                w_a = r_lcm; w_b = r_x; w_ctl = '{start: 1'b1, op: OP_DIV};
                n_st = S_RD_WAIT;
            end
            S_RD_WAIT: if (w_done) begin n_lcm = w_quo; n_st = S_FINISH; end
            S_FINISH: begin
                if (r_sm > (r_ss ? W'(32'h8000_0000) : W'(32'h7FFF_FFFF)) ||
                    r_lcm > W'(32'h7FFF_FFFF) || r_sm > w_lims) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_status = ST_OK;
                    n_on = r_ss ? 32'(-r_sm[31:0]) : r_sm[31:0];
                    n_od = r_lcm[30:0];
                end
                n_st = S_OUT;
            end
            S_OUT: if (m_axis_tready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
        r_s1 <= n_s1; r_s2 <= n_s2; r_ss <= n_ss;
        r_m1 <= n_m1; r_m2 <= n_m2; r_d1 <= n_d1; r_d2 <= n_d2;
        r_x <= n_x; r_y <= n_y; r_lcm <= n_lcm; r_t <= n_t; r_sm <= n_sm;
        r_status <= n_status; r_on <= n_on; r_od <= n_od;
    end

    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = (r_st == S_OUT);
    assign m_axis_tdata  = {7'd0, r_status, r_od, r_on};

    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `ASSERT_IMPL(a_excl, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
    `ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tdata[64:63] != ST_OK |-> m_axis_tdata[62:0] == '0, "error result not zero")
endmodule
